// ----- hdl/kwc_pkg.sv -----
// Shared types, constants and character helpers for the keyword occurrence counter.
package kwc_pkg;

   // Keyword table size and index width.
   localparam int NKEY = 11;
   localparam int KEY_BITS = 4;

   // Word length register width and the length at which a word closes on its own.
   localparam int LEN_BITS = 7;
   localparam logic [LEN_BITS-1:0] WORD_LIMIT = LEN_BITS'(100);

   // Width of the hits field and the default width of each keyword counter.
   localparam int HITS_BITS = 32;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam logic [NKEY-1:0] ALL_FLAGS = '1;

   // Character codes that steer the comment scanner.
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // Keyword spelling, padded with zero bytes, in table order.
   localparam logic [7:0] KEY_TEXT [NKEY][8] = '{
      '{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
      '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
      '{"c", "o", "n", "t", "i", "n", "u", "e"},
      '{"d", "e", "f", "a", "u", "l", "t", 8'h00},
      '{"u", "n", "s", "i", "g", "n", "e", "d"},
      '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "o", "l", "a", "t", "i", "l", "e"},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] KEY_LEN [NKEY] = '{
      4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
   };

   // Scanner modes.
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_SLASH   = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_STAR    = 3'd4
   } scan_mode_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_MATCH  = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_SCAN,
      SEQ_WALK,
      SEQ_TERM
   } seq_state_type;

   // Step strobes from the sequencer to the scanner.
   typedef struct packed {
      logic char_step;
      logic end_step;
   } scan_ctl_type;

   // Keyword match found when a word closes.
   typedef struct packed {
      logic                hit;
      logic [KEY_BITS-1:0] index;
   } close_type;

   // Counter bank controls.
   typedef struct packed {
      logic                inc;
      logic [KEY_BITS-1:0] inc_index;
      logic                clear;
      logic [KEY_BITS-1:0] rd_index;
   } cnt_ctl_type;

   function automatic logic is_start_char(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_start_char(c) || (c inside {[8'h30:8'h39]});
   endfunction

endpackage

// ----- hdl/kwc_scanner.sv -----
// Character scanner: comment skipping, identifier gathering and keyword match flags.
module kwc_scanner (
   input  logic                 clock,
   input  logic                 reset,
   input  kwc_pkg::scan_ctl_type scan_ctl,
   input  logic [7:0]           ch,
   output kwc_pkg::close_type   close
);
   import kwc_pkg::*;

   scan_mode_type       mode_ff, mode_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [NKEY-1:0]     flags_ff, flags_in;

   logic                word_char, start_char, in_word, cont, idle_path, add_en;
   logic                limit_close, early_close;
   logic [LEN_BITS-1:0] base_len, add_len, eval_len;
   logic [NKEY-1:0]     base_flags, keep, add_flags, eval_flags;

   // Character classes and the word extension path.
   always_comb begin
      word_char = is_word_char(ch);
      start_char = is_start_char(ch);
      in_word = (mode_ff == MODE_WORD);
      cont = in_word && word_char;
      idle_path = !(mode_ff inside {MODE_WORD, MODE_SLASH, MODE_COMMENT, MODE_STAR})
                  || (in_word && !word_char)
                  || ((mode_ff == MODE_SLASH) && (ch != CH_STAR));
      add_en = scan_ctl.char_step && (cont || (idle_path && start_char));
      base_len = cont ? len_ff : '0;
      base_flags = cont ? flags_ff : ALL_FLAGS;
      for (int i = 0; i < NKEY; i++) begin
         keep[i] = (base_len < LEN_BITS'(KEY_LEN[i])) && (KEY_TEXT[i][base_len[2:0]] == ch);
      end
      add_flags = base_flags & keep;
      add_len = base_len + LEN_BITS'(1);
   end

   // Word closing and keyword lookup; the lowest table index wins.
   always_comb begin
      limit_close = add_en && (add_len >= WORD_LIMIT);
      early_close = in_word && (scan_ctl.end_step || (scan_ctl.char_step && !word_char));
      eval_len = limit_close ? add_len : len_ff;
      eval_flags = limit_close ? add_flags : flags_ff;
      close.hit = 1'b0;
      close.index = '0;
      for (int i = NKEY - 1; i >= 0; i--) begin
         if ((limit_close || early_close) && eval_flags[i]
             && (eval_len == LEN_BITS'(KEY_LEN[i]))) begin
            close.hit = 1'b1;
            close.index = KEY_BITS'(i);
         end
      end
   end

   // Next scanner state.
   always_comb begin
      mode_in = mode_ff;
      len_in = len_ff;
      flags_in = flags_ff;
      if (scan_ctl.end_step) begin
         mode_in = MODE_IDLE;
         len_in = '0;
         flags_in = ALL_FLAGS;
      end else if (scan_ctl.char_step) begin
         case (mode_ff)
            MODE_SLASH: begin
               if (ch == CH_STAR) begin
                  mode_in = MODE_COMMENT;
               end
            end
            MODE_COMMENT: begin
               if (ch == CH_STAR) begin
                  mode_in = MODE_STAR;
               end
            end
            MODE_STAR: begin
               if (ch == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (ch != CH_STAR) begin
                  mode_in = MODE_COMMENT;
               end
            end
            default: begin
            end
         endcase
         // A fresh character after idle, a closed word or a lone slash.
         if (idle_path) begin
            if (start_char) begin
               mode_in = MODE_WORD;
            end else if (ch == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         if (add_en) begin
            len_in = add_len;
            flags_in = add_flags;
         end
         if (limit_close) begin
            mode_in = MODE_IDLE;
            len_in = '0;
            flags_in = ALL_FLAGS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff <= '0;
         flags_ff <= ALL_FLAGS;
      end else begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- hdl/kwc_counter_bank.sv -----
// Saturating keyword counters with an increment port and a report read port.
module kwc_counter_bank #(
   parameter int COUNT_BITS = kwc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kwc_pkg::cnt_ctl_type          cnt_ctl,
   output logic [kwc_pkg::HITS_BITS-1:0] inc_hits,
   output logic [kwc_pkg::HITS_BITS-1:0] rd_hits,
   output logic                          rd_nonzero
);
   import kwc_pkg::*;

   logic [COUNT_BITS-1:0] counts_ff [NKEY];
   logic [COUNT_BITS-1:0] counts_in [NKEY];
   logic [COUNT_BITS-1:0] inc_sel, inc_sat, rd_sel;

   // Select the counter to bump and the counter to report.
   always_comb begin
      inc_sel = '0;
      rd_sel = '0;
      for (int i = 0; i < NKEY; i++) begin
         if (cnt_ctl.inc_index == KEY_BITS'(i)) begin
            inc_sel = counts_ff[i];
         end
         if (cnt_ctl.rd_index == KEY_BITS'(i)) begin
            rd_sel = counts_ff[i];
         end
      end
      inc_sat = (inc_sel == '1) ? inc_sel : inc_sel + COUNT_BITS'(1);
      inc_hits = HITS_BITS'(inc_sat);
      rd_hits = HITS_BITS'(rd_sel);
      rd_nonzero = (rd_sel != '0);
   end

   // Next counter values.
   always_comb begin
      for (int i = 0; i < NKEY; i++) begin
         if (cnt_ctl.clear) begin
            counts_in[i] = '0;
         end else if (cnt_ctl.inc && (cnt_ctl.inc_index == KEY_BITS'(i))) begin
            counts_in[i] = inc_sat;
         end else begin
            counts_in[i] = counts_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NKEY; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         counts_ff <= counts_in;
      end
   end

endmodule

// ----- hdl/kwc_sequencer.sv -----
// Step control, end-of-stream report walk and the result register.
module kwc_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_cmd,
   input  kwc_pkg::close_type            close,
   input  logic [kwc_pkg::HITS_BITS-1:0] inc_hits,
   input  logic [kwc_pkg::HITS_BITS-1:0] rd_hits,
   input  logic                          rd_nonzero,
   output kwc_pkg::scan_ctl_type         scan_ctl,
   output kwc_pkg::cnt_ctl_type          cnt_ctl,
   output logic                          consume,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [kwc_pkg::KEY_BITS-1:0]  rsp_keyword_index,
   output logic [kwc_pkg::HITS_BITS-1:0] rsp_hits,
   output logic                          rsp_last
);
   import kwc_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [KEY_BITS-1:0] walk_ff, walk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [KEY_BITS-1:0] index_ff, index_in;
   logic [HITS_BITS-1:0] hits_ff, hits_in;
   logic                last_ff, last_in;
   logic                room, emit;

   // The result register can take a new result when it is empty or being drained.
   assign room = !rsp_valid_ff || !rsp_stall;

   // Next state and report walk position.
   always_comb begin
      state_in = state_ff;
      walk_in = walk_ff;
      case (state_ff)
         SEQ_SCAN: begin
            if (in_valid && room && in_cmd) begin
               state_in = SEQ_WALK;
               walk_in = '0;
            end
         end
         SEQ_WALK: begin
            if (room) begin
               if (walk_ff == KEY_BITS'(NKEY - 1)) begin
                  state_in = SEQ_TERM;
               end else begin
                  walk_in = walk_ff + KEY_BITS'(1);
               end
            end
         end
         SEQ_TERM: begin
            if (room) begin
               state_in = SEQ_SCAN;
            end
         end
         default: begin
            state_in = SEQ_SCAN;
         end
      endcase
   end

   // Step strobes, counter controls and the result to load.
   always_comb begin
      scan_ctl = '0;
      consume = 1'b0;
      emit = 1'b0;
      kind_in = KIND_MATCH;
      index_in = close.index;
      hits_in = inc_hits;
      last_in = 1'b1;
      cnt_ctl.inc = 1'b0;
      cnt_ctl.inc_index = close.index;
      cnt_ctl.clear = 1'b0;
      cnt_ctl.rd_index = walk_ff;
      case (state_ff)
         SEQ_SCAN: begin
            if (in_valid && room) begin
               scan_ctl.char_step = !in_cmd;
               scan_ctl.end_step = in_cmd;
               consume = !in_cmd;
               cnt_ctl.inc = close.hit;
               emit = close.hit;
               last_in = !in_cmd;
            end
         end
         SEQ_WALK: begin
            if (room) begin
               emit = rd_nonzero;
               kind_in = KIND_REPORT;
               index_in = walk_ff;
               hits_in = rd_hits;
               last_in = 1'b0;
            end
         end
         SEQ_TERM: begin
            if (room) begin
               emit = 1'b1;
               consume = 1'b1;
               cnt_ctl.clear = 1'b1;
               kind_in = KIND_END;
               index_in = '0;
               hits_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register valid: set on a new result, cleared once taken.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_SCAN;
         walk_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_ff <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         index_ff <= index_in;
         hits_ff <= hits_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_keyword_index = index_ff;
   assign rsp_hits = hits_ff;
   assign rsp_last = last_ff;

endmodule

// ----- hdl/keyword_occurrence_counter_top.sv -----
// Top level of the keyword occurrence counter: request register and block wiring.
// Counts C keywords (auto through while) in a character stream. Each request is either one
// character or an end-of-stream command. Character requests are taken one per cycle while the
// result register has room, and a word that spells a keyword produces, when it closes, one
// match result carrying the keyword index and its new saturating count, through the request and
// result registers. An end-of-stream request closes a pending word and clears the scanner, then
// the report sequencer walks the eleven counters of the counter bank, then comes the terminator;
// only nonzero counters produce report lines, and the counters are cleared with the terminator.
// Comments, whitespace and single-character tokens produce nothing. A stalled result
// register holds the block only once the request register is also full.
module keyword_occurrence_counter_top #(
   parameter int COUNT_BITS = kwc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [7:0]                    req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [kwc_pkg::KEY_BITS-1:0]  rsp_keyword_index,
   output logic [kwc_pkg::HITS_BITS-1:0] rsp_hits,
   output logic                          rsp_last
);
   import kwc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         in_cmd_ff;
   logic [7:0]   in_ch_ff;
   logic         consume;
   scan_ctl_type scan_ctl;
   close_type    close;
   cnt_ctl_type  cnt_ctl;
   logic [HITS_BITS-1:0] inc_hits, rd_hits;
   logic         rd_nonzero;

   // The request register refills whenever it is empty or its request is finished.
   assign req_stall = in_valid_ff && !consume;

   always_comb begin
      if (!req_stall) begin
         in_valid_in = req_valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_cmd_ff <= req_cmd;
         in_ch_ff <= req_ch;
      end
   end

   kwc_scanner u_scanner (
      .clock    (clock),
      .reset    (reset),
      .scan_ctl (scan_ctl),
      .ch       (in_ch_ff),
      .close    (close)
   );

   kwc_counter_bank #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter_bank (
      .clock      (clock),
      .reset      (reset),
      .cnt_ctl    (cnt_ctl),
      .inc_hits   (inc_hits),
      .rd_hits    (rd_hits),
      .rd_nonzero (rd_nonzero)
   );

   kwc_sequencer u_sequencer (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (in_valid_ff),
      .in_cmd            (in_cmd_ff),
      .close             (close),
      .inc_hits          (inc_hits),
      .rd_hits           (rd_hits),
      .rd_nonzero        (rd_nonzero),
      .scan_ctl          (scan_ctl),
      .cnt_ctl           (cnt_ctl),
      .consume           (consume),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_keyword_index (rsp_keyword_index),
      .rsp_hits          (rsp_hits),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- bench/keyword_occurrence_counter_top_test.sv -----
// Self-checking testbench for the keyword occurrence counter.

typedef struct packed {
   kwc_pkg::kind_type              kind;
   logic [kwc_pkg::KEY_BITS-1:0]   index;
   logic [kwc_pkg::HITS_BITS-1:0]  hits;
   logic                           last;
} keyword_result_type;

// Follows the scanner and the keyword counters, and holds the results the block still owes.
class keyword_tally_tracker;
   kwc_pkg::scan_mode_type         mode;
   bit [kwc_pkg::LEN_BITS-1:0]     word_len;
   bit [kwc_pkg::NKEY-1:0]         alive;
   longint unsigned                tally [kwc_pkg::NKEY];
   longint unsigned                tally_max;
   keyword_result_type             owed_results [$];
   keyword_result_type             fresh [$];
   int                             mismatch_count;

   function new(int count_bits);
      tally_max = (count_bits >= 64) ? '1 : (64'd1 << count_bits) - 64'd1;
      mismatch_count = 0;
      restart();
   endfunction

   function void restart();
      mode = kwc_pkg::MODE_IDLE;
      word_len = '0;
      alive = kwc_pkg::ALL_FLAGS;
      foreach (tally[i]) tally[i] = 0;
   endfunction

   function bit word_start(bit [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == kwc_pkg::CH_UNDERSCORE;
   endfunction

   function void post(kwc_pkg::kind_type kind, int idx, longint unsigned hits);
      keyword_result_type r;
      r.kind = kind;
      r.index = kwc_pkg::KEY_BITS'(idx);
      r.hits = hits[31:0];
      r.last = 1'b0;
      fresh.push_back(r);
   endfunction

   // A finished word scores the first keyword it still spells and whose length it has.
   function void close_word();
      for (int i = 0; i < kwc_pkg::NKEY; i++) begin
         if (alive[i] && word_len == kwc_pkg::KEY_LEN[i]) begin
            if (tally[i] < tally_max) tally[i]++;
            post(kwc_pkg::KIND_MATCH, i, tally[i]);
            break;
         end
      end
      mode = kwc_pkg::MODE_IDLE;
      word_len = '0;
      alive = kwc_pkg::ALL_FLAGS;
   endfunction

   // Drop every keyword that disagrees at this position, then close the word at the limit.
   function void take_char(bit [7:0] c);
      for (int i = 0; i < kwc_pkg::NKEY; i++) begin
         if (!(word_len < kwc_pkg::KEY_LEN[i] && kwc_pkg::KEY_TEXT[i][word_len[2:0]] == c))
            alive[i] = 1'b0;
      end
      word_len = word_len + 1'b1;
      if (word_len >= kwc_pkg::WORD_LIMIT) close_word();
   endfunction

   // A character seen between tokens: it may open a word or a possible comment.
   function void fresh_char(bit [7:0] c);
      mode = kwc_pkg::MODE_IDLE;
      if (word_start(c)) begin
         mode = kwc_pkg::MODE_WORD;
         word_len = '0;
         alive = kwc_pkg::ALL_FLAGS;
         take_char(c);
      end else if (c == kwc_pkg::CH_SLASH) begin
         mode = kwc_pkg::MODE_SLASH;
      end
   endfunction

   // Work out the results of one accepted request and queue them.
   function void note_request(bit cmd, bit [7:0] c);
      fresh.delete();
      if (cmd) begin
         if (mode == kwc_pkg::MODE_WORD) close_word();
         for (int i = 0; i < kwc_pkg::NKEY; i++)
            if (tally[i] != 0) post(kwc_pkg::KIND_REPORT, i, tally[i]);
         post(kwc_pkg::KIND_END, 0, 0);
         restart();
      end else begin
         case (mode)
            kwc_pkg::MODE_WORD: begin
               if (word_start(c) || (c >= "0" && c <= "9")) begin
                  take_char(c);
               end else begin
                  close_word();
                  fresh_char(c);
               end
            end
            kwc_pkg::MODE_SLASH: begin
               if (c == kwc_pkg::CH_STAR) mode = kwc_pkg::MODE_COMMENT;
               else fresh_char(c);
            end
            kwc_pkg::MODE_COMMENT: begin
               if (c == kwc_pkg::CH_STAR) mode = kwc_pkg::MODE_STAR;
            end
            kwc_pkg::MODE_STAR: begin
               if (c == kwc_pkg::CH_SLASH) mode = kwc_pkg::MODE_IDLE;
               else if (c != kwc_pkg::CH_STAR) mode = kwc_pkg::MODE_COMMENT;
            end
            default: fresh_char(c);
         endcase
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) owed_results.push_back(fresh[i]);
   endfunction

   // Compare one accepted result with the oldest one owed.
   function void check_result(keyword_result_type got);
      keyword_result_type want;
      if (owed_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: kind=%0d index=%0d hits=%0d last=%0d",
                     got.kind, got.index, got.hits, got.last);
         return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind || got.index !== want.index ||
          got.hits !== want.hits || got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"result mismatch: expected kind=%0d index=%0d hits=%0d last=%0d,",
                      " got kind=%0d index=%0d hits=%0d last=%0d"},
                     want.kind, want.index, want.hits, want.last,
                     got.kind, got.index, got.hits, got.last);
      end
   endfunction
endclass

module keyword_occurrence_counter_top_test;
   import kwc_pkg::*;

   localparam int HALF_PERIOD = 6;
   // Narrow eight-bit counters.
   localparam int COUNT_W = 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int STREAM_ITEMS = 410;

   typedef struct packed {
      bit       cmd;
      bit [7:0] ch;
   } char_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = 1'b0;
   logic [7:0]            req_ch = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [KEY_BITS-1:0]   rsp_keyword_index;
   logic [HITS_BITS-1:0]  rsp_hits;
   logic                  rsp_last;

   int unsigned           cycles = 0;
   char_req_type          stream [$];
   keyword_tally_tracker  tracker;

   keyword_occurrence_counter_top #(.COUNT_BITS(COUNT_W)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_ch            (req_ch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_keyword_index (rsp_keyword_index),
      .rsp_hits          (rsp_hits),
      .rsp_last          (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Cycle count and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Waits drawn per item, with regular stretches in which neither side idles.
   function automatic int pause_cycles();
      if ((cycles % 640) < 160) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic void push_char(bit [7:0] c);
      stream.push_back('{cmd: 1'b0, ch: c});
   endfunction

   function automatic void push_text(string s);
      foreach (s[i]) push_char(s[i]);
   endfunction

   function automatic void push_end(bit [7:0] c);
      stream.push_back('{cmd: 1'b1, ch: c});
   endfunction

   function automatic bit [7:0] any_letter();
      if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic bit [7:0] any_word_char();
      case ($urandom_range(0, 3))
         0: return 8'("0" + $urandom_range(0, 9));
         1: return CH_UNDERSCORE;
         default: return any_letter();
      endcase
   endfunction

   // Characters that end a word: whitespace, punctuation, control and high bytes, slash.
   function automatic bit [7:0] any_break_char();
      string marks = ";,(){}[]+-=<>.!#&|";
      case ($urandom_range(0, 5))
         0: return 8'h20;
         1: return 8'($urandom_range(9, 13));
         2: return marks[$urandom_range(0, marks.len() - 1)];
         3: return 8'($urandom_range(128, 255));
         4: return 8'($urandom_range(0, 31));
         default: return CH_SLASH;
      endcase
   endfunction

   // Spell a keyword, now and then bent into a near miss.
   function automatic void push_keyword(int k, bit mutate);
      bit [7:0] spell [$];
      for (int j = 0; j < int'(KEY_LEN[k]); j++) spell.push_back(KEY_TEXT[k][j]);
      if (mutate) begin
         case ($urandom_range(0, 7))
            0: void'(spell.pop_back());
            1: spell.push_back(any_word_char());
            2: spell[$urandom_range(0, spell.size() - 1)] = any_letter();
            3: spell[0] = spell[0] - 8'd32;
            default: ;
         endcase
      end
      foreach (spell[i]) push_char(spell[i]);
   endfunction

   // Random tokens: mostly keywords and words, with comments, noise and end commands.
   function automatic void push_random_token();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         push_keyword($urandom_range(0, NKEY - 1), 1'b1);
         if ($urandom_range(0, 5) != 0) push_char(any_break_char());
      end else if (pick < 12) begin
         push_text("/*");
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
               0: push_keyword($urandom_range(0, NKEY - 1), 1'b0);
               1: push_char(CH_STAR);
               2: push_char(CH_SLASH);
               default: push_char(8'($urandom_range(0, 255)));
            endcase
         end
         repeat ($urandom_range(1, 3)) push_char(CH_STAR);
         push_char(CH_SLASH);
      end else if (pick < 14) begin
         push_char($urandom_range(0, 3) == 0 ? CH_UNDERSCORE : any_letter());
         repeat ($urandom_range(0, 8)) push_char(any_word_char());
         push_char(any_break_char());
      end else if (pick < 16) begin
         push_char(8'($urandom_range(0, 255)));
      end else if (pick == 16 && $urandom_range(0, 3) == 0) begin
         // A word around the length limit, followed by a keyword, a digit or a break character.
         push_char(any_letter());
         repeat ($urandom_range(94, 109)) push_char(any_word_char());
         case ($urandom_range(0, 2))
            0: push_keyword($urandom_range(0, NKEY - 1), 1'b0);
            1: push_char(8'("0" + $urandom_range(0, 9)));
            default: push_char(any_break_char());
         endcase
      end else if (pick == 17) begin
         push_end(8'($urandom_range(0, 255)));
      end else begin
         push_char(any_break_char());
      end
   endfunction

   // Present one request after a drawn idle time and hold it until the block takes it.
   task automatic drive_request(char_req_type r);
      int gap;
      gap = pause_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_ch <= r.ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(r.cmd, r.ch);
   endtask

   // Stall for a drawn number of cycles, then take and check the next result.
   task automatic take_result();
      int wait_cycles;
      keyword_result_type got;
      wait_cycles = pause_cycles();
      if (wait_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (wait_cycles) @(posedge clock);
         rsp_stall <= 1'b0;
      end
      do @(posedge clock);
      while (reset !== 1'b0 || rsp_valid !== 1'b1 || rsp_stall !== 1'b0);
      got.kind = kind_type'(rsp_kind);
      got.index = rsp_keyword_index;
      got.hits = rsp_hits;
      got.last = rsp_last;
      tracker.check_result(got);
   endtask

   // Request side: build the stream, release reset, then send every request.
   initial begin : request_side
      tracker = new(COUNT_W);

      // Directed: a keyword ended by a zero byte, a word cut by a slash, a comment closed
      // by a run of stars, a high byte, end of stream with a pending word, inside a
      // comment and after a lone slash.
      push_text("case");
      push_char(8'h00);
      push_text("/void/***/");
      push_char(8'hFF);
      push_end(8'hFF);
      push_text("char");
      push_end(8'h00);
      push_text("/*x");
      push_end(8'h5A);
      push_char(CH_SLASH);
      push_end(CH_SLASH);

      while (stream.size() < STREAM_ITEMS - 1) push_random_token();
      push_end(8'($urandom_range(0, 255)));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stream[n]) drive_request(stream[n]);
      req_valid <= 1'b0;

      while (tracker.owed_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.owed_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: take and check results for the whole run.
   initial begin : result_side
      forever take_result();
   end

endmodule

// ----- keyword_occurrence_counter_top.f -----
hdl/kwc_pkg.sv
hdl/kwc_scanner.sv
hdl/kwc_counter_bank.sv
hdl/kwc_sequencer.sv
hdl/keyword_occurrence_counter_top.sv
bench/keyword_occurrence_counter_top_test.sv
